>>> sv/rmsp_pkg.sv
// ----------------------------------------------------------------------------
// rmsp_pkg: shared types and constants for the read memory size profiler
// Word payload structs, request codes, status codes and parameter defaults.
// ----------------------------------------------------------------------------
package rmsp_pkg;

   // parameter defaults
   localparam int ADDR_BITS_DEF   = 16;
   localparam int STACK_DEPTH_DEF = 64;
   localparam int TIME_BITS_DEF   = 32;

   // request codes
   localparam logic [2:0] REQ_CALL   = 3'd0;
   localparam logic [2:0] REQ_RETURN = 3'd1;
   localparam logic [2:0] REQ_READ   = 3'd2;
   localparam logic [2:0] REQ_WRITE  = 3'd3;
   localparam logic [2:0] REQ_ADD    = 3'd4;

   // response status codes
   localparam logic [1:0] STS_FRAME     = 2'd0;
   localparam logic [1:0] STS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STS_UNDERFLOW = 2'd2;

   // command queue depth
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [31:0] func_id;
      logic [15:0] addr;
      logic [15:0] length;
      logic [31:0] cost_amount;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] frame_func;
      logic [31:0] frame_start;
      logic [31:0] frame_size;
      logic [47:0] frame_cost;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      OP_CALL   = 3'd0,
      OP_RETURN = 3'd1,
      OP_READ   = 3'd2,
      OP_WRITE  = 3'd3,
      OP_ADD    = 3'd4
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] func_id;
      logic [15:0] addr;
      logic [15:0] length;
      logic [31:0] cost_amount;
   } cmd_type;

   typedef struct packed {
      logic clearing;
      logic busy;
   } back_status_type;

endpackage

>>> sv/rmsp_front.sv
// ----------------------------------------------------------------------------
// rmsp_front: request intake and command queue
// Holds the enable register, drops ignored words and queues the rest.
// ----------------------------------------------------------------------------
module rmsp_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  rmsp_pkg::req_payload_type req_payload,
   input  logic                     csr_wr_en,
   input  logic                     csr_wr_data,
   input  rmsp_pkg::back_status_type back_status,
   output logic                     cmd_valid,
   output rmsp_pkg::cmd_type        cmd,
   input  logic                     cmd_pop
);
   import rmsp_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic            enable_ff, enable_in;
   cmd_type         q_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            accept, keep, push;
   cmd_type         new_cmd;

   assign req_ready = !back_status.clearing && (cnt_ff != CW'(QUEUE_DEPTH));
   assign accept    = req_valid && req_ready;
   // unknown codes and a disabled block leave no trace
   assign keep      = enable_ff && (req_payload.req_type <= REQ_ADD);
   assign push      = accept && keep;

   assign new_cmd.op          = op_type'(req_payload.req_type);
   assign new_cmd.func_id     = req_payload.func_id;
   assign new_cmd.addr        = req_payload.addr;
   assign new_cmd.length      = req_payload.length;
   assign new_cmd.cost_amount = req_payload.cost_amount;

   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rp_ff];

   // queue pointers and enable
   always_comb begin
      enable_in = csr_wr_en ? csr_wr_data : enable_ff;
      wp_in     = push ? PW'((32'(wp_ff) + 1) % QUEUE_DEPTH) : wp_ff;
      rp_in     = cmd_pop ? PW'((32'(rp_ff) + 1) % QUEUE_DEPTH) : rp_ff;
      cnt_in    = cnt_ff + CW'(push) - CW'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         wp_ff     <= '0;
         rp_ff     <= '0;
         cnt_ff    <= '0;
      end else begin
         enable_ff <= enable_in;
         wp_ff     <= wp_in;
         rp_ff     <= rp_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= new_cmd;
      end
   end

endmodule

>>> sv/rmsp_back.sv
// ----------------------------------------------------------------------------
// rmsp_back: command execution
// Stamp memory with clearing pass, frame stack, byte walk and stack search.
// ----------------------------------------------------------------------------
module rmsp_back #(
   parameter int ADDR_BITS   = rmsp_pkg::ADDR_BITS_DEF,
   parameter int STACK_DEPTH = rmsp_pkg::STACK_DEPTH_DEF,
   parameter int TIME_BITS   = rmsp_pkg::TIME_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_valid,
   input  rmsp_pkg::cmd_type         cmd,
   output logic                      cmd_pop,
   output rmsp_pkg::back_status_type back_status,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rmsp_pkg::rsp_payload_type rsp_payload
);
   import rmsp_pkg::*;

   localparam int IW = $clog2(STACK_DEPTH);
   localparam int DW = $clog2(STACK_DEPTH + 1);

   typedef struct packed {
      logic [31:0]          func;
      logic [TIME_BITS-1:0] start;
      logic [31:0]          size;
      logic [47:0]          cost;
   } frame_type;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_RET, S_RANGE, S_CHECK, S_SEARCH
   } state_type;

   state_type            state_ff, state_in;
   logic [ADDR_BITS-1:0] clr_ff, clr_in;
   logic [TIME_BITS-1:0] counter_ff, counter_in;
   logic [DW-1:0]        depth_ff, depth_in;
   frame_type            top_ff, top_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [15:0]          len_ff, len_in;
   logic                 is_read_ff, is_read_in;
   logic [IW-1:0]        j_ff, j_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_ff, rsp_in;

   // memories
   logic [TIME_BITS-1:0] stamps [2**ADDR_BITS];
   logic [TIME_BITS-1:0] sm_rd_ff;
   logic                 sm_en, sm_we;
   logic [ADDR_BITS-1:0] sm_addr;
   logic [TIME_BITS-1:0] sm_wdata;
   frame_type            frames [STACK_DEPTH];
   frame_type            fm_rd_ff;
   logic                 fm_re, fm_we;
   logic [IW-1:0]        fm_raddr, fm_waddr;
   frame_type            fm_wdata;

   logic                     full, emits, stall;
   logic [47:0]              ret_cost;
   logic [ADDR_BITS+15:0]    addr_ext;
   logic [TIME_BITS+31:0]    start_ext;
   logic [IW-1:0]            top_idx, parent_idx;

   assign full       = (depth_ff == DW'(STACK_DEPTH));
   assign emits      = (cmd.op == OP_RETURN) || ((cmd.op == OP_CALL) && full);
   assign stall      = emits && rsp_valid_ff && !rsp_ready;
   assign ret_cost   = top_ff.cost + {16'd0, cmd.cost_amount};
   assign addr_ext   = {{ADDR_BITS{1'b0}}, cmd.addr};
   assign start_ext  = {32'd0, top_ff.start};
   assign top_idx    = IW'(depth_ff - DW'(1));
   assign parent_idx = IW'(depth_ff - DW'(2));

   assign cmd_pop              = (state_ff == S_IDLE) && cmd_valid && !stall;
   assign back_status.clearing = (state_ff == S_CLEAR);
   assign back_status.busy     = (state_ff != S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_payload          = rsp_ff;

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      counter_in   = counter_ff;
      depth_in     = depth_ff;
      top_in       = top_ff;
      addr_in      = addr_ff;
      len_in       = len_ff;
      is_read_in   = is_read_ff;
      j_in         = j_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      sm_en        = 1'b0;
      sm_we        = 1'b0;
      sm_addr      = addr_ff;
      sm_wdata     = counter_ff;
      fm_re        = 1'b0;
      fm_we        = 1'b0;
      fm_raddr     = parent_idx;
      fm_waddr     = top_idx;
      fm_wdata     = top_ff;

      unique case (state_ff)
         // zero every stamp once after reset
         S_CLEAR: begin
            sm_en    = 1'b1;
            sm_we    = 1'b1;
            sm_addr  = clr_ff;
            sm_wdata = '0;
            clr_in   = clr_ff + ADDR_BITS'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd_pop) begin
               unique case (cmd.op)
                  OP_CALL: begin
                     if (full) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{STS_OVERFLOW, 32'd0, 32'd0, 32'd0, 48'd0};
                     end else begin
                        // spill current top, new frame goes in registers
                        fm_we        = (depth_ff != '0);
                        counter_in   = counter_ff + TIME_BITS'(1);
                        top_in.func  = cmd.func_id;
                        top_in.start = counter_ff + TIME_BITS'(1);
                        top_in.size  = '0;
                        top_in.cost  = '0;
                        depth_in     = depth_ff + DW'(1);
                     end
                  end
                  OP_RETURN: begin
                     rsp_valid_in = 1'b1;
                     if (depth_ff == '0) begin
                        rsp_in = '{STS_UNDERFLOW, 32'd0, 32'd0, 32'd0, 48'd0};
                     end else begin
                        rsp_in = '{STS_FRAME, top_ff.func, start_ext[31:0],
                                   top_ff.size, ret_cost};
                        top_in.cost = ret_cost;
                        depth_in    = depth_ff - DW'(1);
                        if (depth_ff != DW'(1)) begin
                           fm_re    = 1'b1;
                           state_in = S_RET;
                        end
                     end
                  end
                  OP_READ, OP_WRITE: begin
                     addr_in    = addr_ext[ADDR_BITS-1:0];
                     len_in     = cmd.length;
                     is_read_in = (cmd.op == OP_READ);
                     state_in   = S_RANGE;
                  end
                  OP_ADD: begin
                     if (depth_ff != '0) begin
                        top_in.size = top_ff.size + {16'd0, cmd.length};
                     end
                  end
                  default: ;
               endcase
            end
         end
         // fold the returned frame into its parent
         S_RET: begin
            top_in.func  = fm_rd_ff.func;
            top_in.start = fm_rd_ff.start;
            top_in.size  = fm_rd_ff.size + top_ff.size;
            top_in.cost  = fm_rd_ff.cost + top_ff.cost;
            state_in     = S_IDLE;
         end
         // one byte per visit: fetch old stamp, write new one
         S_RANGE: begin
            if (len_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               sm_en    = 1'b1;
               sm_we    = 1'b1;
               addr_in  = addr_ff + ADDR_BITS'(1);
               len_in   = len_ff - 16'd1;
               state_in = is_read_ff ? S_CHECK : S_RANGE;
            end
         end
         S_CHECK: begin
            state_in = S_RANGE;
            if ((depth_ff != '0) && (sm_rd_ff < top_ff.start)) begin
               top_in.size = top_ff.size + 32'd1;
               if ((sm_rd_ff != '0) && (depth_ff > DW'(1))) begin
                  fm_re    = 1'b1;
                  j_in     = parent_idx;
                  state_in = S_SEARCH;
               end
            end
         end
         // walk down the stack for the frame that last saw this byte
         S_SEARCH: begin
            if (fm_rd_ff.start <= sm_rd_ff) begin
               fm_we         = 1'b1;
               fm_waddr      = j_ff;
               fm_wdata      = fm_rd_ff;
               fm_wdata.size = fm_rd_ff.size - 32'd1;
               state_in      = S_RANGE;
            end else if (j_ff == '0) begin
               state_in = S_RANGE;
            end else begin
               fm_re    = 1'b1;
               fm_raddr = j_ff - IW'(1);
               j_in     = j_ff - IW'(1);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         counter_ff   <= '0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         counter_ff   <= counter_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      top_ff     <= top_in;
      addr_ff    <= addr_in;
      len_ff     <= len_in;
      is_read_ff <= is_read_in;
      j_ff       <= j_in;
      rsp_ff     <= rsp_in;
   end

   // stamp memory, read before write
   always_ff @(posedge clock) begin
      if (sm_en) begin
         sm_rd_ff <= stamps[sm_addr];
         if (sm_we) begin
            stamps[sm_addr] <= sm_wdata;
         end
      end
   end

   // frames below the top
   always_ff @(posedge clock) begin
      if (fm_we) begin
         frames[fm_waddr] <= fm_wdata;
      end
      if (fm_re) begin
         fm_rd_ff <= frames[fm_raddr];
      end
   end

endmodule

>>> sv/read_memory_size_profiler.sv
// Read memory size profiler. After reset the block sweeps its byte stamp
// memory, one address per cycle, over all 2**ADDR_BITS addresses (65536 by
// default) with req_ready low; csr writes are taken throughout. Ignored
// words are dropped at intake and never reach the back end; a return whose
// parent lies in frame memory folds into it through S_RET. A write range
// visits S_RANGE once per byte, a read range S_RANGE then S_CHECK, plus an
// S_SEARCH step per stack entry scanned when a byte last touched by an older
// frame is found; the single-port stamp memory and the one-read frame memory
// set this order. A two-word command queue lets requests keep arriving while
// a range is walked, and a result register lets work continue while a result waits.
// ----------------------------------------------------------------------------
// read_memory_size_profiler: top level
// Profiling event intake, execution back end and assertions.
// ----------------------------------------------------------------------------
module read_memory_size_profiler #(
   parameter int ADDR_BITS   = rmsp_pkg::ADDR_BITS_DEF,
   parameter int STACK_DEPTH = rmsp_pkg::STACK_DEPTH_DEF,
   parameter int TIME_BITS   = rmsp_pkg::TIME_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  rmsp_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rmsp_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_wr_en,
   input  logic                      csr_wr_data
);
   import rmsp_pkg::*;

   logic            cmd_valid, cmd_pop;
   cmd_type         cmd;
   back_status_type back_status;

   rmsp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .back_status (back_status),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop)
   );

   rmsp_back #(
      .ADDR_BITS   (ADDR_BITS),
      .STACK_DEPTH (STACK_DEPTH),
      .TIME_BITS   (TIME_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop),
      .back_status (back_status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // no word taken while stamps are being cleared
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      back_status.clearing |-> !req_ready)
      else $error("request accepted during clearing pass");

   // nothing is popped from the queue while the back end is busy
   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (cmd_valid && !back_status.busy))
      else $error("command popped while back end busy");

   // error results carry zero fields
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.status != STS_FRAME)) |->
         ((rsp_payload.frame_func == '0) && (rsp_payload.frame_size == '0) &&
          (rsp_payload.frame_cost == '0)))
      else $error("error result with nonzero fields");

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the read memory size profiler
// A queue-fed driver offers profiling words and a clocked monitor predicts
// each accepted word, checking frame records and stack errors in order,
// across enable settings, idle/stall mixes and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
   import rmsp_pkg::*;

   localparam logic [2:0] REQ_BOGUS = 3'd7;
   localparam int FRAMES = 64;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_wr_en = 1'b0;
   logic csr_wr_data = 1'b0;

   read_memory_size_profiler u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   // words waiting to be offered, and frame records still to come
   req_payload_type event_q[$];
   rsp_payload_type frame_q[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int errors = 0;
   int words_taken = 0;
   int records_seen = 0;
   int errs_seen = 0;
   logic hold_kick = 1'b0;
   int hold_left = 0;

   // shadow of the profiler state
   bit [31:0] stamp_mem [65536];
   bit [31:0] shadow_clock = 0;
   int        shadow_depth = 0;
   bit [31:0] fr_func [FRAMES];
   bit [31:0] fr_start [FRAMES];
   bit [31:0] fr_size [FRAMES];
   bit [47:0] fr_cost [FRAMES];
   bit        shadow_enable = 1'b1;

   task automatic report(input string what, input logic [63:0] got,
                         input logic [63:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
      errors++;
   endtask

   task automatic cmp_field(input string what, input logic [63:0] got,
                            input logic [63:0] want);
      if (got !== want) report(what, got, want);
   endtask

   // apply one accepted word to the shadow state
   task automatic profile_word(input req_payload_type w);
      rsp_payload_type r;
      bit [31:0] old;
      bit [15:0] a;
      int t, j;
      bit found;
      r = '0;
      if (!shadow_enable) return;
      case (w.req_type)
         REQ_CALL: begin
            if (shadow_depth >= FRAMES) begin
               r.status = STS_OVERFLOW;
               frame_q.push_back(r);
            end else begin
               shadow_clock++;
               fr_func[shadow_depth] = w.func_id;
               fr_start[shadow_depth] = shadow_clock;
               fr_size[shadow_depth] = 0;
               fr_cost[shadow_depth] = 0;
               shadow_depth++;
            end
         end
         REQ_RETURN: begin
            if (shadow_depth == 0) begin
               r.status = STS_UNDERFLOW;
            end else begin
               t = shadow_depth - 1;
               fr_cost[t] = fr_cost[t] + w.cost_amount;
               r.status = STS_FRAME;
               r.frame_func = fr_func[t];
               r.frame_start = fr_start[t];
               r.frame_size = fr_size[t];
               r.frame_cost = fr_cost[t];
               if (t > 0) begin
                  fr_size[t-1] = fr_size[t-1] + fr_size[t];
                  fr_cost[t-1] = fr_cost[t-1] + fr_cost[t];
               end
               shadow_depth = t;
            end
            frame_q.push_back(r);
         end
         REQ_READ: begin
            for (int k = 0; k < w.length; k++) begin
               a = w.addr + 16'(k);
               old = stamp_mem[a];
               stamp_mem[a] = shadow_clock;
               if (shadow_depth != 0) begin
                  t = shadow_depth - 1;
                  if (old < fr_start[t]) begin
                     fr_size[t]++;
                     if (old != 0) begin
                        // charge back the nearest frame that saw this byte
                        j = t;
                        found = 1'b0;
                        while (j > 0 && !found) begin
                           j--;
                           if (fr_start[j] <= old) begin
                              fr_size[j]--;
                              found = 1'b1;
                           end
                        end
                     end
                  end
               end
            end
         end
         REQ_WRITE: begin
            for (int k = 0; k < w.length; k++) stamp_mem[w.addr + 16'(k)] = shadow_clock;
         end
         REQ_ADD: begin
            if (shadow_depth > 0)
               fr_size[shadow_depth-1] = fr_size[shadow_depth-1] + w.length;
         end
         default: ;
      endcase
   endtask

   // driver: offer the next word once the current one is taken
   always @(posedge clock) begin : drv
      logic stuck;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         stuck = req_valid && !req_ready;
         if (!stuck) begin
            if (event_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_payload <= event_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (hold_left > 0) hold_left <= hold_left - 1;
      else if (hold_kick) hold_left <= 3000;
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // monitor: check results, then predict the word taken at this edge
   always @(posedge clock) begin : mon
      rsp_payload_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (frame_q.size() == 0) begin
               report("unexpected result", 64'(rsp_payload.status), 64'd0);
            end else begin
               want = frame_q.pop_front();
               cmp_field("status", 64'(rsp_payload.status), 64'(want.status));
               cmp_field("frame_func", 64'(rsp_payload.frame_func),
                         64'(want.frame_func));
               cmp_field("frame_start", 64'(rsp_payload.frame_start),
                         64'(want.frame_start));
               cmp_field("frame_size", 64'(rsp_payload.frame_size),
                         64'(want.frame_size));
               cmp_field("frame_cost", 64'(rsp_payload.frame_cost),
                         64'(want.frame_cost));
               if (want.status == STS_FRAME) records_seen++;
               else errs_seen++;
            end
         end
         if (req_valid && req_ready) begin
            words_taken++;
            profile_word(req_payload);
         end
      end
   end

   task automatic push_word(input logic [2:0] op, input logic [31:0] func,
                            input logic [15:0] addr, input logic [15:0] len,
                            input logic [31:0] cost);
      req_payload_type w;
      w.req_type = op;
      w.func_id = func;
      w.addr = addr;
      w.length = len;
      w.cost_amount = cost;
      event_q.push_back(w);
   endtask

   // wait until every word is taken and every result is in, then settle
   task automatic settle(input int cycles);
      while (event_q.size() != 0 || req_valid || frame_q.size() != 0)
         @(posedge clock);
      repeat (cycles) @(posedge clock);
   endtask

   task automatic csr_write(input logic v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shadow_enable = v;
   endtask

   // random profiling traffic: mostly nested call/range/return sequences
   int gen_depth = 0;
   logic [15:0] win_base = 16'h1000;

   function automatic logic [15:0] pick_addr();
      if ($urandom_range(0, 3) != 0) return win_base + 16'($urandom_range(0, 63));
      return 16'($urandom);
   endfunction

   task automatic gen_events(input int count);
      int made, r;
      made = 0;
      while (made < count) begin
         r = $urandom_range(0, 99);
         if ($urandom_range(0, 29) == 0) win_base = 16'($urandom);
         if (r < 4) begin
            push_word(3'($urandom_range(REQ_ADD + 1, 7)), $urandom, 16'($urandom),
                      16'($urandom), $urandom);
            made--;
         end else if (r < 6) begin
            // run the stack into overflow; the extra calls leave it full
            while (gen_depth < FRAMES + 2) begin
               push_word(REQ_CALL, $urandom, 0, 0, 0);
               gen_depth++;
            end
            gen_depth = FRAMES;
            made += 3;
         end else if (r < 32 && gen_depth < FRAMES) begin
            push_word(REQ_CALL, $urandom, pick_addr(), 16'($urandom), $urandom);
            gen_depth++;
         end else if (r < 56) begin
            push_word(REQ_RETURN, $urandom, pick_addr(), 16'($urandom), $urandom);
            if (gen_depth > 0) gen_depth--;
         end else if (r < 80) begin
            push_word(REQ_READ, $urandom, pick_addr(), 16'($urandom_range(0, 40)),
                      $urandom);
         end else if (r < 92) begin
            push_word(REQ_WRITE, $urandom, pick_addr(),
                      16'($urandom_range(0, 9) == 0 ? $urandom_range(0, 1500)
                                                   : $urandom_range(0, 40)), $urandom);
         end else begin
            push_word(REQ_ADD, $urandom, pick_addr(), 16'($urandom), $urandom);
         end
         made++;
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      csr_write(1'b1);

      // directed: empty-stack cases, wrap, extremes, charge-back, big range
      push_word(REQ_RETURN, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      push_word(REQ_READ, 0, 16'h0010, 16'd4, 0);
      push_word(REQ_ADD, 0, 0, 16'd9, 0);
      push_word(REQ_CALL, 32'h0000_0000, 0, 0, 0);
      push_word(REQ_WRITE, 0, 16'hFFF8, 16'd16, 0);
      push_word(REQ_CALL, 32'hFFFF_FFFF, 0, 0, 0);
      push_word(REQ_READ, 0, 16'hFFFC, 16'd8, 0);
      push_word(REQ_READ, 0, 16'h0010, 16'd4, 0);
      push_word(REQ_WRITE, 0, 16'h0000, 16'd0, 0);
      push_word(REQ_READ, 0, 16'h0000, 16'd0, 0);
      push_word(REQ_CALL, 32'hA5A5_5A5A, 0, 0, 0);
      push_word(REQ_READ, 0, 16'hFFFA, 16'd12, 0);
      push_word(REQ_ADD, 0, 0, 16'hFFFF, 0);
      push_word(REQ_RETURN, 0, 0, 0, 32'hFFFF_FFFF);
      push_word(REQ_RETURN, 0, 0, 0, 32'h0000_0000);
      push_word(REQ_RETURN, 0, 0, 0, 32'h1234_5678);
      push_word(REQ_RETURN, 0, 0, 0, 0);
      push_word(REQ_BOGUS, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      push_word(REQ_WRITE, 0, 16'h0000, 16'hFFFF, 0);
      settle(70000);

      // no idling
      gen_events(60);
      settle(3000);

      // disabled: everything ignored
      csr_write(1'b0);
      gen_events(20);
      settle(3000);
      csr_write(1'b1);

      send_idle_pct = 61;
      gen_events(60);
      settle(3000);
      send_idle_pct = 0;
      recv_stall_pct = 61;
      gen_events(60);
      settle(3000);
      send_idle_pct = 17;
      recv_stall_pct = 17;
      gen_events(60);
      settle(3000);

      // receiver holds off while frames keep coming, filling the block
      send_idle_pct = 0;
      recv_stall_pct = 0;
      @(posedge clock);
      hold_kick <= 1'b1;
      @(posedge clock);
      hold_kick <= 1'b0;
      for (int i = 0; i < 20; i++) begin
         push_word(REQ_CALL, $urandom, 0, 0, 0);
         push_word(REQ_READ, 0, 16'h2000 + 16'(i), 16'd3, 0);
         push_word(REQ_RETURN, 0, 0, 0, $urandom);
      end
      settle(0);

      // sender pauses above until drained, then a last burst
      gen_events(60);
      settle(3000);

      $display("covered %0d words, %0d frame records, %0d stack errors",
               words_taken, records_seen, errs_seen);
      $display("enable on/off, idle and stall mixes, long output hold-off");
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d results outstanding", frame_q.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
